>>> src/hrlc_pkg.sv
package hrlc_pkg;

    typedef logic [7:0] char_t;

    // Field being parsed within the request line.
    typedef enum logic [1:0] {
        PHASE_METHOD  = 2'd0,
        PHASE_URI     = 2'd1,
        PHASE_VERSION = 2'd2,
        PHASE_EXTRA   = 2'd3
    } phase_t;

    localparam int unsigned METHOD_COUNT = 3;

    localparam char_t CHAR_SPACE = 8'h20;
    localparam char_t CHAR_DOT   = 8'h2E;
    localparam char_t CHAR_ZERO  = 8'h30;
    localparam char_t CHAR_NINE  = 8'h39;
    localparam char_t CHAR_UC_A  = 8'h41;
    localparam char_t CHAR_UC_Z  = 8'h5A;
    localparam char_t CHAR_LC_A  = 8'h61;
    localparam char_t CHAR_LC_Z  = 8'h7A;

    // Method spellings, padded with zeros to eight positions so that a
    // three-bit position indexes every row directly.
    localparam char_t METHOD_TEXT [METHOD_COUNT][8] = '{
        '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00, 8'h00}
    };

    localparam logic [2:0] METHOD_LEN [METHOD_COUNT] = '{3'd3, 3'd4, 3'd6};

    localparam logic [2:0] VERSION_PREFIX_LEN = 3'd5;
    localparam logic [2:0] VERSION_IN_MINOR   = 3'd6;

    localparam char_t VERSION_PREFIX [8] = '{
        8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h00, 8'h00, 8'h00
    };

    localparam logic [2:0] METHOD_POS_MAX = 3'd7;

endpackage

>>> src/http_request_line_checker.sv
// Checks one HTTP request line (CR LF removed) delivered one byte per request,
// with is_last set on the final byte. The line must split on exactly two
// spaces into a method (GET, POST or DELETE), a URI of letters only (possibly
// empty) and a version of the form HTTP/ followed by digits with at most one
// inner dot. One verdict (0 valid, 1 bad request) is returned for each line,
// in response to its last byte; other bytes return nothing. Every byte is
// handled by a small state update, so a byte can be taken on
// every clock; the only stall comes from a verdict still waiting in the
// output register while out_ready is low. After a verdict the parser is back
// in its start state for the next line.
module http_request_line_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] line_byte,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       verdict
);

    hrlc_pkg::phase_t phase_reg, phase_next;
    logic [2:0] method_pos_reg, method_pos_next;
    logic [2:0] method_cand_reg, method_cand_next;
    logic [2:0] version_pos_reg, version_pos_next;
    logic       dot_seen_reg, dot_seen_next;
    logic       prev_dot_reg, prev_dot_next;
    logic       line_bad_reg, line_bad_next;
    logic       out_valid_reg, out_valid_next;
    logic       verdict_reg;

    logic       in_fire;
    logic       method_done;
    logic       is_letter;
    logic       is_digit;
    logic       bad_now;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    // A taken last byte loads a verdict; otherwise a taken verdict empties the register.
    assign out_valid_next = (in_fire && is_last) || (out_valid_reg && !out_ready);

    assign is_letter = ((line_byte >= hrlc_pkg::CHAR_UC_A) && (line_byte <= hrlc_pkg::CHAR_UC_Z))
                    || ((line_byte >= hrlc_pkg::CHAR_LC_A) && (line_byte <= hrlc_pkg::CHAR_LC_Z));
    assign is_digit  = (line_byte >= hrlc_pkg::CHAR_ZERO) && (line_byte <= hrlc_pkg::CHAR_NINE);

    always_comb
    begin
        method_done = 1'b0;
        for (int i = 0; i < hrlc_pkg::METHOD_COUNT; i++)
        begin
            if (method_cand_reg[i] && (method_pos_reg == hrlc_pkg::METHOD_LEN[i]))
            begin
                method_done = 1'b1;
            end
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        method_pos_next  = method_pos_reg;
        method_cand_next = method_cand_reg;
        version_pos_next = version_pos_reg;
        dot_seen_next    = dot_seen_reg;
        prev_dot_next    = prev_dot_reg;
        line_bad_next    = line_bad_reg;

        if (line_byte == hrlc_pkg::CHAR_SPACE)
        begin
            case (phase_reg)
                hrlc_pkg::PHASE_METHOD:
                begin
                    if (!method_done)
                    begin
                        line_bad_next = 1'b1;
                    end
                    phase_next = hrlc_pkg::PHASE_URI;
                end
                hrlc_pkg::PHASE_URI:
                begin
                    phase_next = hrlc_pkg::PHASE_VERSION;
                end
                default:
                begin
                    phase_next    = hrlc_pkg::PHASE_EXTRA;
                    line_bad_next = 1'b1;
                end
            endcase
        end
        else
        begin
            case (phase_reg)
                hrlc_pkg::PHASE_METHOD:
                begin
                    for (int i = 0; i < hrlc_pkg::METHOD_COUNT; i++)
                    begin
                        if ((method_pos_reg >= hrlc_pkg::METHOD_LEN[i])
                            || (hrlc_pkg::METHOD_TEXT[i][method_pos_reg] != line_byte))
                        begin
                            method_cand_next[i] = 1'b0;
                        end
                    end
                    if (method_pos_reg != hrlc_pkg::METHOD_POS_MAX)
                    begin
                        method_pos_next = method_pos_reg + 3'd1;
                    end
                end
                hrlc_pkg::PHASE_URI:
                begin
                    if (!is_letter)
                    begin
                        line_bad_next = 1'b1;
                    end
                end
                hrlc_pkg::PHASE_VERSION:
                begin
                    if (version_pos_reg < hrlc_pkg::VERSION_PREFIX_LEN)
                    begin
                        if (line_byte != hrlc_pkg::VERSION_PREFIX[version_pos_reg])
                        begin
                            line_bad_next = 1'b1;
                        end
                        version_pos_next = version_pos_reg + 3'd1;
                    end
                    else
                    begin
                        if (line_byte == hrlc_pkg::CHAR_DOT)
                        begin
                            // A dot right after the slash, or a second dot, is bad.
                            if ((version_pos_reg == hrlc_pkg::VERSION_PREFIX_LEN)
                                || dot_seen_reg)
                            begin
                                line_bad_next = 1'b1;
                            end
                            dot_seen_next = 1'b1;
                            prev_dot_next = 1'b1;
                        end
                        else
                        begin
                            if (!is_digit)
                            begin
                                line_bad_next = 1'b1;
                            end
                            prev_dot_next = 1'b0;
                        end
                        version_pos_next = hrlc_pkg::VERSION_IN_MINOR;
                    end
                end
                default:
                begin
                    // After a third space the rest of the line is ignored.
                end
            endcase
        end
    end

    assign bad_now = line_bad_next
                  || (phase_next != hrlc_pkg::PHASE_VERSION)
                  || (version_pos_next != hrlc_pkg::VERSION_IN_MINOR)
                  || prev_dot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= hrlc_pkg::PHASE_METHOD;
            method_pos_reg  <= 3'd0;
            method_cand_reg <= 3'b111;
            version_pos_reg <= 3'd0;
            dot_seen_reg    <= 1'b0;
            prev_dot_reg    <= 1'b0;
            line_bad_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                if (is_last)
                begin
                    phase_reg       <= hrlc_pkg::PHASE_METHOD;
                    method_pos_reg  <= 3'd0;
                    method_cand_reg <= 3'b111;
                    version_pos_reg <= 3'd0;
                    dot_seen_reg    <= 1'b0;
                    prev_dot_reg    <= 1'b0;
                    line_bad_reg    <= 1'b0;
                end
                else
                begin
                    phase_reg       <= phase_next;
                    method_pos_reg  <= method_pos_next;
                    method_cand_reg <= method_cand_next;
                    version_pos_reg <= version_pos_next;
                    dot_seen_reg    <= dot_seen_next;
                    prev_dot_reg    <= prev_dot_next;
                    line_bad_reg    <= line_bad_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && is_last)
        begin
            verdict_reg <= bad_now;
        end
    end

    // A new verdict appears only after a last byte was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_fire && is_last))
        else $error("verdict raised without a last byte");

    // The parser is back at the start of a line after each verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_last) |=> (phase_reg == hrlc_pkg::PHASE_METHOD)
            && (method_pos_reg == 3'd0) && (method_cand_reg == 3'b111)
            && (version_pos_reg == 3'd0) && !line_bad_reg)
        else $error("parser state not cleared after last byte");

    // The version position never runs past the minor-digit mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        version_pos_reg <= hrlc_pkg::VERSION_IN_MINOR)
        else $error("version position out of range");

    // With no verdict pending the block always takes a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output register");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned ITEM_TARGET   = 1250;
    localparam int unsigned MAX_GAP       = 14;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned STALL_LIMIT   = 3000;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam logic        VERDICT_OK    = 1'b0;
    localparam logic        VERDICT_BAD   = 1'b1;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] line_byte;
    logic       is_last;
    logic       out_valid;
    logic       out_ready;
    logic       verdict;

    // Predicted parser state for the line currently being received.
    hrlc_pkg::phase_t parse_phase;
    logic [2:0] method_pos;
    logic [2:0] method_live;
    logic [2:0] version_pos;
    logic       dot_seen;
    logic       last_was_dot;
    logic       line_bad;

    string method_names [3] = '{"GET", "POST", "DELETE"};
    string version_prefix   = "HTTP/";

    logic            expected_verdicts [$];
    hrlc_pkg::char_t line_buf [$];
    logic            expected_now;
    int unsigned     mismatch_count = 0;
    int unsigned     bytes_sent     = 0;
    int unsigned     idle_cycles    = 0;
    bit              sender_burst   = 1'b0;
    bit              receiver_burst = 1'b0;
    bit              hold_requested = 1'b0;

    http_request_line_checker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .line_byte (line_byte),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .verdict   (verdict)
    );

    always #6 clk = ~clk;

    function automatic void clear_parser();
        parse_phase  = hrlc_pkg::PHASE_METHOD;
        method_pos   = 3'd0;
        method_live  = 3'b111;
        version_pos  = 3'd0;
        dot_seen     = 1'b0;
        last_was_dot = 1'b0;
        line_bad     = 1'b0;
    endfunction

    function automatic void predict_byte(input hrlc_pkg::char_t c, input logic last);
        bit matched;
        matched = 1'b0;
        if (c == hrlc_pkg::CHAR_SPACE)
        begin
            case (parse_phase)
                hrlc_pkg::PHASE_METHOD:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (method_live[i] && method_pos == method_names[i].len())
                            matched = 1'b1;
                    end
                    if (!matched)
                        line_bad = 1'b1;
                    parse_phase = hrlc_pkg::PHASE_URI;
                end
                hrlc_pkg::PHASE_URI:
                    parse_phase = hrlc_pkg::PHASE_VERSION;
                default:
                begin
                    parse_phase = hrlc_pkg::PHASE_EXTRA;
                    line_bad    = 1'b1;
                end
            endcase
        end
        else if (parse_phase == hrlc_pkg::PHASE_METHOD)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (method_pos >= method_names[i].len() || method_names[i][method_pos] != c)
                    method_live[i] = 1'b0;
            end
            if (method_pos != 3'd7)
                method_pos = method_pos + 3'd1;
        end
        else if (parse_phase == hrlc_pkg::PHASE_URI)
        begin
            if (!((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")))
                line_bad = 1'b1;
        end
        else if (parse_phase == hrlc_pkg::PHASE_VERSION)
        begin
            if (version_pos < 3'd5)
            begin
                if (c != version_prefix[version_pos])
                    line_bad = 1'b1;
                version_pos = version_pos + 3'd1;
            end
            else
            begin
                if (c == hrlc_pkg::CHAR_DOT)
                begin
                    // A dot right after the slash or a second dot spoils the version.
                    if (version_pos == 3'd5 || dot_seen)
                        line_bad = 1'b1;
                    dot_seen     = 1'b1;
                    last_was_dot = 1'b1;
                end
                else
                begin
                    if (c < hrlc_pkg::CHAR_ZERO || c > hrlc_pkg::CHAR_NINE)
                        line_bad = 1'b1;
                    last_was_dot = 1'b0;
                end
                version_pos = hrlc_pkg::VERSION_IN_MINOR;
            end
        end
        if (last)
        begin
            if (line_bad || parse_phase != hrlc_pkg::PHASE_VERSION
                    || version_pos != hrlc_pkg::VERSION_IN_MINOR || last_was_dot)
                expected_verdicts.push_back(VERDICT_BAD);
            else
                expected_verdicts.push_back(VERDICT_OK);
            clear_parser();
        end
    endfunction

    task automatic note_mismatch(input string what, input logic want, input logic got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch at %0t: %s, expected verdict %0b, got %0b",
                     $realtime, what, want, got);
    endtask

    // Bytes are predicted and verdicts checked in one process, so that a verdict
    // and the last byte of the next line meeting at one edge stay in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_byte(line_byte, is_last);
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                    note_mismatch("verdict with no line pending", 1'bx, verdict);
                else
                begin
                    expected_now = expected_verdicts.pop_front();
                    if (verdict !== expected_now)
                        note_mismatch("wrong verdict", expected_now, verdict);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Verdict receiver: random stalls, bursts without stalls, and one long hold.
    initial
    begin
        int unsigned wait_cycles;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_requested)
            begin
                hold_requested = 1'b0;
                wait_cycles    = HOLD_CYCLES;
            end
            else if (receiver_burst)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(0, MAX_GAP);
            if (wait_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_byte(input hrlc_pkg::char_t b, input logic last);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        line_byte <= b;
        is_last   <= last;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_byte(line_buf[i], i == line_buf.size() - 1);
    endtask

    function automatic void append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    task automatic send_text(input string s);
        line_buf.delete();
        append_text(s);
        send_line();
    endtask

    function automatic void build_good_line();
        int unsigned digits;
        int unsigned dot_at;
        line_buf.delete();
        append_text(method_names[$urandom_range(0, 2)]);
        line_buf.push_back(hrlc_pkg::CHAR_SPACE);
        repeat ($urandom_range(0, 6))
        begin
            if ($urandom_range(0, 1))
                line_buf.push_back(hrlc_pkg::char_t'(
                    $urandom_range(hrlc_pkg::CHAR_UC_A, hrlc_pkg::CHAR_UC_Z)));
            else
                line_buf.push_back(hrlc_pkg::char_t'(
                    $urandom_range(hrlc_pkg::CHAR_LC_A, hrlc_pkg::CHAR_LC_Z)));
        end
        line_buf.push_back(hrlc_pkg::CHAR_SPACE);
        append_text(version_prefix);
        digits = $urandom_range(1, 4);
        dot_at = (digits > 1 && $urandom_range(0, 1)) ? $urandom_range(1, digits - 1) : 0;
        for (int i = 0; i < digits; i++)
        begin
            if (dot_at != 0 && i == dot_at)
                line_buf.push_back(hrlc_pkg::CHAR_DOT);
            line_buf.push_back(hrlc_pkg::char_t'(
                $urandom_range(hrlc_pkg::CHAR_ZERO, hrlc_pkg::CHAR_NINE)));
        end
    endfunction

    function automatic void damage_line();
        int unsigned pos;
        pos = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 6))
            0: line_buf[pos] = hrlc_pkg::char_t'($urandom_range(0, 255));
            1: line_buf.insert(pos, hrlc_pkg::CHAR_SPACE);
            2: if (line_buf.size() > 1) line_buf.delete(pos);
            3: while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
            4: line_buf.push_back(hrlc_pkg::CHAR_DOT);
            5: line_buf[pos] = line_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
            default: line_buf.insert(pos, hrlc_pkg::CHAR_DOT);
        endcase
    endfunction

    task automatic test_good_lines();
        send_text("GET abc HTTP/1.1");
        send_text("GET  HTTP/1");
        send_text("POST IndexPage HTTP/10.25");
        send_text("DELETE zZ HTTP/2");
    endtask

    task automatic test_space_and_method_errors();
        send_text("GET a HTTP/1.1 ");
        send_text("GET a HTTP/1 x9 y.");
        send_text("GET a");
        send_text("GET");
        send_text(" a HTTP/1");
        send_text(" ");
        send_text("GETX a HTTP/1");
        send_text("GE a HTTP/1");
        send_text("DELETEDELETE a HTTP/1");
        send_text("GET a1 HTTP/1");
    endtask

    task automatic test_version_errors();
        send_text("GET a HTTP/");
        send_text("GET a HTTP/.1");
        send_text("GET a HTTP/1.");
        send_text("GET a HTTP/1.2.3");
        send_text("GET a HTTx/1");
        send_text("GET a HTT");
        send_text("POST b HTTP/1a");
    endtask

    task automatic test_non_ascii_bytes();
        send_text("G");
        line_buf.delete();
        line_buf.push_back(8'h00);
        send_line();
        send_text("GET x HTTP/1");
        line_buf.delete();
        append_text("GET x HTTP/1");
        line_buf[4] = 8'hC1;
        send_line();
        line_buf[4]  = "x";
        line_buf[11] = 8'hFF;
        send_line();
        line_buf[11] = "1";
        line_buf[0]  = 8'h80;
        send_line();
    endtask

    task automatic test_random_lines();
        int unsigned pick;
        while (bytes_sent < ITEM_TARGET)
        begin
            sender_burst   = ($urandom_range(0, 4) == 0);
            receiver_burst = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                line_buf.delete();
                repeat ($urandom_range(1, 12))
                begin
                    if ($urandom_range(0, 3) == 0)
                        line_buf.push_back(hrlc_pkg::CHAR_SPACE);
                    else
                        line_buf.push_back(hrlc_pkg::char_t'($urandom_range(0, 255)));
                end
            end
            else
            begin
                build_good_line();
                if (pick <= 4)
                begin
                    repeat ($urandom_range(1, 2)) damage_line();
                end
            end
            send_line();
        end
        sender_burst   = 1'b0;
        receiver_burst = 1'b0;
    endtask

    // The receiver holds off while short lines keep coming, so verdicts back up
    // and the checker has to stall its input.
    task automatic test_output_stall();
        hold_requested = 1'b1;
        sender_burst   = 1'b1;
        repeat (20)
        begin
            build_good_line();
            if ($urandom_range(0, 2) == 0)
                damage_line();
            send_line();
        end
        sender_burst = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        line_byte = 8'h00;
        is_last   = 1'b0;
        clear_parser();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_good_lines();
        test_space_and_method_errors();
        test_version_errors();
        test_non_ascii_bytes();
        test_output_stall();
        test_random_lines();

        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

>>> sim.f
src/hrlc_pkg.sv
src/http_request_line_checker.sv
verif/testbench.sv
